// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rgb2hsv_pkg.sv =====
// Types and constants shared by the RGB to HSV pipeline.
`default_nettype none

package rgb2hsv_pkg;

   localparam int CHAN_W     = 8;
   localparam int FRAC_W     = 10;
   localparam int SCALED_W   = 11;
   localparam int PCT_W      = 7;
   localparam int HUE_W      = 9;
   localparam int QUO_W      = 11;
   localparam int REM_W      = 21;
   localparam int DIV_STAGES = QUO_W;
   localparam int PROD_W     = SCALED_W + PCT_W;
   localparam int HUE_SUM_W  = 14;
   localparam int HUE_PROD_W = 21;
   localparam int HUE_DEG_W  = 11;
   localparam int DATA_W     = 24;

   localparam logic [PCT_W-1:0]    PERCENT    = 7'd100;
   localparam logic [SCALED_W-1:0] GRAY_LIMIT = 11'd3;
   localparam logic [QUO_W-1:0]    SAT_LIMIT  = 11'd3;
   localparam logic [HUE_W-1:0]    FULL_CIRCLE = 9'd360;
   localparam logic signed [HUE_PROD_W-1:0] DEG_PER_SEXTANT = 21'sd60;

   // Hue base in units of two sextants: red, green, blue, and red wrapped past 360.
   localparam logic [1:0] BASE_RED   = 2'd0;
   localparam logic [1:0] BASE_GREEN = 2'd1;
   localparam logic [1:0] BASE_BLUE  = 2'd2;
   localparam logic [1:0] BASE_WRAP  = 2'd3;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] den;
      logic [QUO_W-1:0] quo;
   } lane_type;

   typedef struct packed {
      logic             hue_neg;
      logic [1:0]       hue_base;
      logic             gray;
      logic [PCT_W-1:0] brightness;
   } side_type;

   typedef struct packed {
      side_type side;
      lane_type hue;
      lane_type sat;
   } div_word_type;

endpackage

`default_nettype wire

// ===== hdl/rgb2hsv_front.sv =====
// Front stages: channel scaling, then max/min, sector pick and divider operands.
`default_nettype none

module rgb2hsv_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   input  wire logic [rgb2hsv_pkg::CHAN_W-1:0]   red,
   input  wire logic [rgb2hsv_pkg::CHAN_W-1:0]   green,
   input  wire logic [rgb2hsv_pkg::CHAN_W-1:0]   blue,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output rgb2hsv_pkg::div_word_type             out_word
);
   import rgb2hsv_pkg::*;

   // 1024*c/255 equals 4*c plus floor(4*c/255), which is a count of thresholds.
   function automatic logic [SCALED_W-1:0] scale_chan(input logic [CHAN_W-1:0] c);
      logic [2:0] corr;
      corr = 3'(c >= 8'd64) + 3'(c >= 8'd128) + 3'(c >= 8'd192) + 3'(c == 8'd255);
      return {1'b0, c, 2'b00} + SCALED_W'(corr);
   endfunction

   logic                valid1_ff;
   logic                valid2_ff;
   logic                ready1;
   logic                ready2;
   logic [SCALED_W-1:0] red_ff;
   logic [SCALED_W-1:0] green_ff;
   logic [SCALED_W-1:0] blue_ff;
   div_word_type        word_ff;
   div_word_type        word_in;

   logic                    red_top;
   logic                    green_top;
   logic [SCALED_W-1:0]     mx;
   logic [SCALED_W-1:0]     mn;
   logic [SCALED_W-1:0]     delta;
   logic [SCALED_W-1:0]     diff_a;
   logic [SCALED_W-1:0]     diff_b;
   logic signed [SCALED_W:0] diff;
   logic [SCALED_W-1:0]     diff_mag;
   logic [PROD_W-1:0]       sat_prod;
   logic [PROD_W-1:0]       val_prod;

   assign ready2   = !valid2_ff || out_ready;
   assign ready1   = !valid1_ff || ready2;
   assign in_ready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (ready1) begin
            valid1_ff <= in_valid;
         end
         if (ready2) begin
            valid2_ff <= valid1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         red_ff   <= scale_chan(red);
         green_ff <= scale_chan(green);
         blue_ff  <= scale_chan(blue);
      end
      if (ready2 && valid1_ff) begin
         word_ff <= word_in;
      end
   end

   always_comb begin
      red_top   = (red_ff >= green_ff) && (red_ff >= blue_ff);
      green_top = !red_top && (green_ff >= blue_ff);
      mx = red_top ? red_ff : (green_top ? green_ff : blue_ff);
      if (red_ff <= green_ff && red_ff <= blue_ff) begin
         mn = red_ff;
      end else if (green_ff <= blue_ff) begin
         mn = green_ff;
      end else begin
         mn = blue_ff;
      end
      delta = mx - mn;

      if (red_top) begin
         diff_a = green_ff;
         diff_b = blue_ff;
      end else if (green_top) begin
         diff_a = blue_ff;
         diff_b = red_ff;
      end else begin
         diff_a = red_ff;
         diff_b = green_ff;
      end
      diff     = $signed({1'b0, diff_a}) - $signed({1'b0, diff_b});
      diff_mag = diff[SCALED_W] ? SCALED_W'(-diff) : diff[SCALED_W-1:0];

      sat_prod = PROD_W'(delta) * PROD_W'(PERCENT);
      val_prod = PROD_W'(mx) * PROD_W'(PERCENT);

      word_in.side.hue_neg = diff[SCALED_W];
      if (red_top) begin
         word_in.side.hue_base = (green_ff < blue_ff) ? BASE_WRAP : BASE_RED;
      end else if (green_top) begin
         word_in.side.hue_base = BASE_GREEN;
      end else begin
         word_in.side.hue_base = BASE_BLUE;
      end
      word_in.side.gray       = (delta < GRAY_LIMIT) || (mx == '0);
      word_in.side.brightness = val_prod[FRAC_W+PCT_W-1:FRAC_W];

      word_in.hue.rem = REM_W'({diff_mag, FRAC_W'(0)});
      word_in.hue.den = QUO_W'(delta);
      word_in.hue.quo = '0;
      word_in.sat.rem = REM_W'(sat_prod);
      word_in.sat.den = QUO_W'(mx);
      word_in.sat.quo = '0;
   end

   assign out_valid = valid2_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

// ===== hdl/rgb2hsv_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage for both lanes.
`default_nettype none

module rgb2hsv_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire rgb2hsv_pkg::div_word_type in_word,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output rgb2hsv_pkg::div_word_type out_word
);
   import rgb2hsv_pkg::*;

   // The dividend is always below den shifted by QUO_W, so QUO_W steps finish it.
   function automatic lane_type div_step(input lane_type lane, input int unsigned bit_pos);
      lane_type         res;
      logic [REM_W-1:0] trial;
      res   = lane;
      trial = REM_W'(lane.den) << bit_pos;
      if (lane.rem >= trial) begin
         res.rem = lane.rem - trial;
         res.quo = lane.quo | (QUO_W'(1) << bit_pos);
      end
      return res;
   endfunction

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES:0]   ready_w;
   logic [DIV_STAGES:0]   stage_v;
   div_word_type          stage_q [DIV_STAGES+1];
   div_word_type          word_ff [DIV_STAGES];

   assign stage_v[0]          = in_valid;
   assign stage_q[0]          = in_word;
   assign ready_w[DIV_STAGES] = out_ready;
   assign in_ready            = ready_w[0];

   genvar k;
   for (k = 0; k < DIV_STAGES; k++) begin : g_step
      div_word_type step_w;

      assign ready_w[k]   = !valid_ff[k] || ready_w[k+1];
      assign stage_v[k+1] = valid_ff[k];
      assign stage_q[k+1] = word_ff[k];

      always_comb begin
         step_w     = stage_q[k];
         step_w.hue = div_step(stage_q[k].hue, QUO_W - 1 - k);
         step_w.sat = div_step(stage_q[k].sat, QUO_W - 1 - k);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready_w[k]) begin
            valid_ff[k] <= stage_v[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ready_w[k] && stage_v[k]) begin
            word_ff[k] <= step_w;
         end
      end
   end

   assign out_valid = stage_v[DIV_STAGES];
   assign out_word  = stage_q[DIV_STAGES];

endmodule

`default_nettype wire

// ===== hdl/rgb2hsv_back.sv =====
// Back stages: signed hue, scaling to degrees, wrap, and the output register.
`default_nettype none

module rgb2hsv_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire rgb2hsv_pkg::div_word_type     in_word,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [rgb2hsv_pkg::HUE_W-1:0]      hue,
   output logic [rgb2hsv_pkg::PCT_W-1:0]      saturation,
   output logic [rgb2hsv_pkg::PCT_W-1:0]      brightness
);
   import rgb2hsv_pkg::*;

   logic                          valid_a_ff;
   logic                          valid_b_ff;
   logic                          ready_a;
   logic                          ready_b;

   logic signed [QUO_W:0]         quo_signed;
   logic signed [HUE_SUM_W-1:0]   hue_sum;
   logic signed [HUE_PROD_W-1:0]  hue_prod_in;
   logic signed [HUE_PROD_W-1:0]  hue_prod_ff;
   logic [PCT_W-1:0]              sat_ff;
   logic                          sat_low_ff;
   logic                          gray_ff;
   logic [PCT_W-1:0]              bright_a_ff;

   logic signed [HUE_DEG_W-1:0]   hue_deg;
   logic signed [HUE_DEG_W-1:0]   hue_wrap;
   logic [HUE_W-1:0]              hue_in;
   logic [PCT_W-1:0]              sat_in;
   logic [HUE_W-1:0]              hue_ff;
   logic [PCT_W-1:0]              sat_out_ff;
   logic [PCT_W-1:0]              bright_ff;

   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   // The quotient is a magnitude; the sector base adds 0, 2, 4 or 6 sextants.
   always_comb begin
      quo_signed  = in_word.side.hue_neg ? -$signed({1'b0, in_word.hue.quo})
                                         : $signed({1'b0, in_word.hue.quo});
      hue_sum     = HUE_SUM_W'(quo_signed) +
                    $signed({1'b0, in_word.side.hue_base, (QUO_W)'(0)});
      hue_prod_in = HUE_PROD_W'(hue_sum) * DEG_PER_SEXTANT;
   end

   always_comb begin
      hue_deg  = HUE_DEG_W'(hue_prod_ff >>> FRAC_W);
      hue_wrap = hue_deg[HUE_DEG_W-1] ? (hue_deg + HUE_DEG_W'(FULL_CIRCLE)) : hue_deg;
      hue_in   = (gray_ff || sat_low_ff) ? '0 : hue_wrap[HUE_W-1:0];
      sat_in   = gray_ff ? '0 : sat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            valid_a_ff <= in_valid;
         end
         if (ready_b) begin
            valid_b_ff <= valid_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         hue_prod_ff <= hue_prod_in;
         sat_ff      <= in_word.sat.quo[PCT_W-1:0];
         sat_low_ff  <= in_word.sat.quo < SAT_LIMIT;
         gray_ff     <= in_word.side.gray;
         bright_a_ff <= in_word.side.brightness;
      end
      if (ready_b && valid_a_ff) begin
         hue_ff     <= hue_in;
         sat_out_ff <= sat_in;
         bright_ff  <= bright_a_ff;
      end
   end

   assign out_valid  = valid_b_ff;
   assign hue        = hue_ff;
   assign saturation = sat_out_ff;
   assign brightness = bright_ff;

endmodule

`default_nettype wire

// ===== hdl/rgb_to_hsv_converter.sv =====
// Pixel-stream RGB to HSV converter: fifteen-stage pipeline, one pixel per clock while the result side keeps up.
//
// Takes one 8-bit RGB pixel per word and returns hue in degrees (0..359),
// saturation and value in percent (0..100). A new pixel is accepted on every
// clock while the result side keeps up. The restoring divider, which
// produces one quotient bit per stage for saturation and hue side by side over
// eleven stages, lies between two front stages (channel scaling, max/min and
// sector) and two back stages (degree scaling and the output register).
// Stalls on the result side hold every stage; empty stages still fill.
`default_nettype none
`include "assert_macros.svh"

module rgb_to_hsv_converter (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  wire logic [rgb2hsv_pkg::DATA_W-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // hue [8:0], saturation [15:9], brightness [22:16], zero [23]
   output logic [rgb2hsv_pkg::DATA_W-1:0]        rsp_tdata
);
   import rgb2hsv_pkg::*;

   logic             front_valid;
   logic             front_ready;
   div_word_type     front_word;
   logic             div_valid;
   logic             div_ready;
   div_word_type     div_word;
   logic [HUE_W-1:0] hue;
   logic [PCT_W-1:0] saturation;
   logic [PCT_W-1:0] brightness;

   rgb2hsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .red       (req_tdata[CHAN_W-1:0]),
      .green     (req_tdata[2*CHAN_W-1:CHAN_W]),
      .blue      (req_tdata[3*CHAN_W-1:2*CHAN_W]),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_word  (front_word)
   );

   rgb2hsv_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_word  (div_word)
   );

   rgb2hsv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_ready   (div_ready),
      .in_word    (div_word),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .hue        (hue),
      .saturation (saturation),
      .brightness (brightness)
   );

   assign rsp_tdata = DATA_W'({brightness, saturation, hue});

   // An empty output register means every stage upstream can take a word.
   `ASSERT_IMPLIES(a_ready_when_drained, !rsp_tvalid, req_tready, "input stalled while output empty")
   `ASSERT_IMPLIES(a_hue_range, rsp_tvalid, rsp_tdata[HUE_W-1:0] < FULL_CIRCLE, "hue out of range")
   `ASSERT_IMPLIES(a_pct_range, rsp_tvalid, (saturation <= PERCENT) && (brightness <= PERCENT), "percent out of range")
   `ASSERT_IMPLIES(a_weak_sat_hue, rsp_tvalid && (saturation < PCT_W'(SAT_LIMIT)), hue == '0, "hue set for weak saturation")

endmodule

`default_nettype wire

// ===== bench/rgb_to_hsv_converter_tb.sv =====
// Self-checking testbench for the RGB to HSV converter pixel stream.
`timescale 1ns / 100ps

module rgb_to_hsv_converter_tb;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 3;
   localparam int MAX_GAP       = 16;
   localparam int DRAIN_CYCLES  = 40;
   localparam int STALL_LIMIT   = 2000;
   localparam int LONG_HOLD     = 150;

   // Fixed-point constants of the conversion: channels scale to 1/1024 units.
   localparam int FRAC          = 10;
   localparam int CHAN_FULL     = 255;
   localparam int PERCENT       = 100;
   localparam int GRAY_LIMIT    = 3;
   localparam int SAT_LIMIT     = 3;
   localparam int SEXTANT       = 1 << FRAC;
   localparam int DEG_PER_SEXT  = 60;
   localparam int FULL_CIRCLE   = 360;

   typedef struct packed {
      logic [rgb2hsv_pkg::HUE_W-1:0] hue;
      logic [rgb2hsv_pkg::PCT_W-1:0] saturation;
      logic [rgb2hsv_pkg::PCT_W-1:0] brightness;
   } hsv_pixel_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [rgb2hsv_pkg::DATA_W-1:0]  req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [rgb2hsv_pkg::DATA_W-1:0]  rsp_tdata;

   hsv_pixel_type pending_hsv[$];
   int error_count   = 0;
   int send_gap_max  = MAX_GAP;
   int recv_gap_max  = MAX_GAP;
   int hold_cycles   = 0;

   rgb_to_hsv_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic hsv_pixel_type rgb_to_hsv(input logic [7:0] red8,
                                                input logic [7:0] green8,
                                                input logic [7:0] blue8);
      hsv_pixel_type hsv;
      int r, g, b, mx, mn, delta, sat, h;
      r = (int'(red8) << FRAC) / CHAN_FULL;
      g = (int'(green8) << FRAC) / CHAN_FULL;
      b = (int'(blue8) << FRAC) / CHAN_FULL;
      mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      delta = mx - mn;
      hsv.brightness = 7'((PERCENT * mx) >> FRAC);
      hsv.saturation = '0;
      hsv.hue = '0;
      if (delta >= GRAY_LIMIT && mx != 0) begin
         sat = (PERCENT * delta) / mx;
         hsv.saturation = 7'(sat);
         if (sat >= SAT_LIMIT) begin
            // Signed division truncates toward zero, the shift below floors.
            if (mx == r)
               h = ((g - b) * SEXTANT) / delta + ((g < b) ? 6 * SEXTANT : 0);
            else if (mx == g)
               h = ((b - r) * SEXTANT) / delta + 2 * SEXTANT;
            else
               h = ((r - g) * SEXTANT) / delta + 4 * SEXTANT;
            h = (h * DEG_PER_SEXT) >>> FRAC;
            if (h < 0)
               h += FULL_CIRCLE;
            hsv.hue = 9'(h);
         end
      end
      return hsv;
   endfunction

   // Offers one pixel and returns at the falling edge after it was taken.
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         req_tdata  = 24'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {blue, green, red};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_hsv.push_back(rgb_to_hsv(red, green, blue));
      @(negedge clock);
   endtask

   // Stops offering pixels and waits until every expected word has arrived.
   task automatic wait_for_results();
      req_tvalid = 1'b0;
      req_tdata  = 24'($urandom);
      while (pending_hsv.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [7:0] clamp_channel(input int value);
      return (value < 0) ? 8'd0 : (value > CHAN_FULL) ? 8'd255 : 8'(value);
   endfunction

   task automatic send_random_pixel();
      logic [7:0] red, green, blue;
      int base;
      red   = 8'($urandom);
      green = 8'($urandom);
      blue  = 8'($urandom);
      case ($urandom_range(0, 4))
         0: begin
            // Channels within a few steps of each other: gray and weakly saturated.
            base  = $urandom_range(0, CHAN_FULL);
            red   = clamp_channel(base + $urandom_range(0, 8) - 4);
            green = clamp_channel(base + $urandom_range(0, 8) - 4);
            blue  = clamp_channel(base + $urandom_range(0, 8) - 4);
         end
         1: begin
            // Two channels tie, often for the largest one.
            case ($urandom_range(0, 2))
               0: green = red;
               1: blue = green;
               default: blue = red;
            endcase
         end
         2: begin
            red   = $urandom_range(0, 1) ? 8'd255 : red;
            green = $urandom_range(0, 1) ? 8'd0 : green;
            blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         end
         default: ;
      endcase
      send_pixel(red, green, blue);
   endtask

   task automatic test_named_colors();
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd100, 8'd101, 8'd100);
      // Saturation just below and exactly at the threshold where hue is kept.
      send_pixel(8'd255, 8'd250, 8'd250);
      send_pixel(8'd200, 8'd196, 8'd196);
      send_pixel(8'd255, 8'd247, 8'd247);
      // Negative sector quotients in each sector, positive ones in the red and blue sectors.
      send_pixel(8'd255, 8'd0,   8'd10);
      send_pixel(8'd100, 8'd255, 8'd0);
      send_pixel(8'd200, 8'd10,  8'd255);
      send_pixel(8'd50,  8'd10,  8'd200);
      send_pixel(8'd255, 8'd254, 8'd0);
      send_pixel(8'd170, 8'd85,  8'd255);
      send_pixel(8'd85,  8'd170, 8'd255);
      wait_for_results();
   endtask

   task automatic test_random_pixels(input int count);
      for (int i = 0; i < count; i++) begin
         // Every 40 words, switch between random gaps and full rate on each side.
         if (i % 40 == 0) begin
            send_gap_max = $urandom_range(0, 2) == 0 ? 0 : MAX_GAP;
            recv_gap_max = $urandom_range(0, 2) == 0 ? 0 : MAX_GAP;
         end
         send_random_pixel();
      end
      wait_for_results();
   endtask

   task automatic test_output_backpressure(input int count);
      send_gap_max = 0;
      recv_gap_max = MAX_GAP;
      hold_cycles  = LONG_HOLD;
      for (int i = 0; i < count; i++)
         send_random_pixel();
      wait_for_results();
   endtask

   task automatic test_full_rate(input int count);
      send_gap_max = 0;
      recv_gap_max = 0;
      for (int i = 0; i < count; i++)
         send_random_pixel();
      wait_for_results();
   endtask

   initial begin : result_receiver
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         stall = $urandom_range(0, recv_gap_max);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid && hold_cycles == 0);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : result_checker
      hsv_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hsv.size() == 0) begin
            $error("unexpected word on rsp: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_hsv.pop_front();
            if (rsp_tdata[8:0] !== want.hue) begin
               $error("hue: expected %0d, actual %0d", want.hue, rsp_tdata[8:0]);
               error_count++;
            end
            if (rsp_tdata[15:9] !== want.saturation) begin
               $error("saturation: expected %0d, actual %0d", want.saturation,
                      rsp_tdata[15:9]);
               error_count++;
            end
            if (rsp_tdata[22:16] !== want.brightness) begin
               $error("brightness: expected %0d, actual %0d", want.brightness,
                      rsp_tdata[22:16]);
               error_count++;
            end
            if (rsp_tdata[23] !== 1'b0) begin
               $error("pad: expected 0, actual %b", rsp_tdata[23]);
               error_count++;
            end
         end
      end
   end

   initial begin : stall_watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL rgb_to_hsv_converter");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;
      test_named_colors();
      test_random_pixels(300);
      test_output_backpressure(60);
      test_full_rate(60);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("PASS rgb_to_hsv_converter");
      else
         $display("FAIL rgb_to_hsv_converter");
      $finish;
   end

endmodule
